// ===== design/dsst_pkg.sv =====
// ----------------------------------------------------------------------------
// Descending score table package
// Types and constants shared by the sorted table, its cells and its checker.
// ----------------------------------------------------------------------------
package dsst_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int RANK_W      = 6;

   typedef struct packed {
      logic [15:0] player_id;
      logic [15:0] score;
   } req_type;

   typedef struct packed {
      logic [RANK_W-1:0] rank;
      logic [15:0]       entry_player;
      logic [15:0]       entry_score;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] player;
      logic [15:0] score;
   } entry_type;

   // Control broadcast from the sequencer to every cell.
   typedef struct packed {
      logic        insert;
      logic        rotate;
      logic [15:0] new_player;
      logic [15:0] new_score;
   } cell_ctrl_type;

   typedef enum logic {
      ST_IDLE,
      ST_LIST
   } state_type;

endpackage

// ===== design/descending_score_sorted_table.sv =====
// ----------------------------------------------------------------------------
// Descending score sorted table
// A chain of cells kept in descending score order; each insert lists the table.
// ----------------------------------------------------------------------------
// Insert: the cells take the new entry when it is accepted; rank 0 is offered in the next cycle.
// Listing: the ring of TABLE_DEPTH cells rotates once per result transfer and
// once per cycle over empty cells, TABLE_DEPTH rotations in all, which restores
// the order. A new insert is accepted only once the listing has ended.
// Reset clears every cell's valid bit and returns the sequencer to idle.
module descending_score_sorted_table (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dsst_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dsst_pkg::rsp_type rsp_payload
);

   localparam int DEPTH = dsst_pkg::TABLE_DEPTH;
   localparam int IW    = dsst_pkg::IDX_W;

   dsst_pkg::state_type     state_ff;
   dsst_pkg::state_type     state_in;
   logic [IW-1:0]           rank_ff;
   logic [IW-1:0]           rank_in;
   logic                    step;
   logic                    rank_end;
   dsst_pkg::cell_ctrl_type ctrl;
   dsst_pkg::entry_type     cells [DEPTH];
   logic                    lower [DEPTH];

   assign rank_end = (rank_ff == IW'(DEPTH - 1));
   // Empty cells at the tail rotate by without a transfer.
   assign step     = cells[0].valid ? rsp_ready : 1'b1;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dsst_pkg::ST_IDLE: if (req_valid) state_in = dsst_pkg::ST_LIST;
         dsst_pkg::ST_LIST: if (step && rank_end) state_in = dsst_pkg::ST_IDLE;
         default:           state_in = dsst_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready       = (state_ff == dsst_pkg::ST_IDLE);
      rsp_valid       = (state_ff == dsst_pkg::ST_LIST) && cells[0].valid;
      ctrl.insert     = req_valid && req_ready;
      ctrl.rotate     = (state_ff == dsst_pkg::ST_LIST) && step;
      ctrl.new_player = req_payload.player_id;
      ctrl.new_score  = req_payload.score;
      rank_in         = rank_ff;
      if (ctrl.insert) begin
         rank_in = '0;
      end else if (ctrl.rotate) begin
         rank_in = rank_ff + IW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dsst_pkg::ST_IDLE;
         rank_ff  <= '0;
      end else begin
         state_ff <= state_in;
         rank_ff  <= rank_in;
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam int PREV = (i == 0) ? 0 : i - 1;
      localparam int NEXT = (i == DEPTH - 1) ? 0 : i + 1;
      logic prev_lower;
      assign prev_lower = (i == 0) ? 1'b0 : lower[PREV];

      dsst_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .prev_lower (prev_lower),
         .prev_entry (cells[PREV]),
         .next_entry (cells[NEXT]),
         .lower      (lower[i]),
         .entry      (cells[i])
      );
   end

   assign rsp_payload.rank         = dsst_pkg::RANK_W'(rank_ff);
   assign rsp_payload.entry_player = cells[0].player;
   assign rsp_payload.entry_score  = cells[0].score;
   // Cell 1 holds the following rank, so an empty cell 1 marks the end.
   assign rsp_payload.last         = rank_end || !cells[1].valid;

endmodule

// ===== design/dsst_cell.sv =====
// ----------------------------------------------------------------------------
// Sorted table cell
// Holds one table entry. On an insert it keeps its entry, takes the new one,
// or takes its upper neighbor's; while listing it takes its lower neighbor's.
// ----------------------------------------------------------------------------
module dsst_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  dsst_pkg::cell_ctrl_type ctrl,
   input  logic                   prev_lower,
   input  dsst_pkg::entry_type    prev_entry,
   input  dsst_pkg::entry_type    next_entry,
   output logic                   lower,
   output dsst_pkg::entry_type    entry
);

   logic        valid_ff;
   logic        valid_in;
   logic [15:0] player_ff;
   logic [15:0] player_in;
   logic [15:0] score_ff;
   logic [15:0] score_in;

   // An empty cell ranks below everything, so the new entry fills the table
   // from the top.
   assign lower = !valid_ff || (score_ff < ctrl.new_score);

   always_comb begin
      priority if (ctrl.rotate) begin
         valid_in  = next_entry.valid;
         player_in = next_entry.player;
         score_in  = next_entry.score;
      end else if (ctrl.insert && lower) begin
         if (prev_lower) begin
            valid_in  = prev_entry.valid;
            player_in = prev_entry.player;
            score_in  = prev_entry.score;
         end else begin
            valid_in  = 1'b1;
            player_in = ctrl.new_player;
            score_in  = ctrl.new_score;
         end
      end else begin
         valid_in  = valid_ff;
         player_in = player_ff;
         score_in  = score_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      player_ff <= player_in;
      score_ff  <= score_in;
   end

   assign entry.valid  = valid_ff;
   assign entry.player = player_ff;
   assign entry.score  = score_ff;

endmodule

// ===== design/dsst_checker.sv =====
// ----------------------------------------------------------------------------
// Sorted table port checker
// Watches the ports of the sorted table for listing order and stall behavior.
// ----------------------------------------------------------------------------
module dsst_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input dsst_pkg::rsp_type rsp_payload
);

   // No insert is taken while a listing is being offered.
   a_no_insert_in_listing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("insert accepted during a listing");

   // Each insert starts a listing at rank 0.
   a_listing_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (rsp_valid && rsp_payload.rank == '0 && !req_ready))
      else $error("listing did not start at rank 0");

   // A transfer that is not the last is followed by the next rank.
   a_rank_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_payload.last) |=>
         (rsp_valid && rsp_payload.rank == $past(rsp_payload.rank) + 6'd1))
      else $error("listing broke off or skipped a rank");

   // A stalled result holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled result changed");

endmodule

bind descending_score_sorted_table dsst_checker u_dsst_checker (.*);

// ===== sim/dsst_table_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Descending score table checker
// Watches both channels of the sorted table and keeps its own ranked copy of
// the table. Every accepted insert queues the full listing it should produce,
// and every result transfer is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module dsst_table_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  dsst_pkg::req_type req_payload,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  dsst_pkg::rsp_type rsp_payload,
   output int                fail_count,
   output int                pending
);

   logic [15:0]       ranked_player [dsst_pkg::TABLE_DEPTH];
   logic [15:0]       ranked_score  [dsst_pkg::TABLE_DEPTH];
   int unsigned       ranked_count;
   dsst_pkg::rsp_type listing_q [$];
   int                mismatches = 0;

   task automatic report_mismatch(input string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      mismatches++;
   endtask

   // Stable insert: the new entry lands after every entry with an equal or
   // higher score. A full table drops its lowest entry, or the new one when
   // it would rank last.
   task automatic ranked_insert(input dsst_pkg::req_type item);
      int unsigned       pos;
      int unsigned       tail;
      dsst_pkg::rsp_type line;
      pos = 0;
      while (pos < ranked_count && ranked_score[pos] >= item.score)
         pos++;
      if (pos < dsst_pkg::TABLE_DEPTH) begin
         tail = (ranked_count < dsst_pkg::TABLE_DEPTH) ? ranked_count
                                                       : dsst_pkg::TABLE_DEPTH - 1;
         for (int unsigned i = tail; i > pos; i--) begin
            ranked_player[i] = ranked_player[i-1];
            ranked_score[i]  = ranked_score[i-1];
         end
         ranked_player[pos] = item.player_id;
         ranked_score[pos]  = item.score;
         if (ranked_count < dsst_pkg::TABLE_DEPTH)
            ranked_count++;
      end
      for (int unsigned i = 0; i < ranked_count; i++) begin
         line.rank         = dsst_pkg::RANK_W'(i);
         line.entry_player = ranked_player[i];
         line.entry_score  = ranked_score[i];
         line.last         = (i + 1 == ranked_count);
         listing_q         = {listing_q, line};
      end
   endtask

   task automatic check_result(input dsst_pkg::rsp_type got);
      dsst_pkg::rsp_type want;
      if (listing_q.size() == 0) begin
         report_mismatch($sformatf("unexpected result rank %0d player %h score %h last %b",
                                   got.rank, got.entry_player, got.entry_score, got.last));
         return;
      end
      want = listing_q.pop_front();
      if (got.rank != want.rank)
         report_mismatch($sformatf("rank got %0d want %0d", got.rank, want.rank));
      if (got.entry_player != want.entry_player)
         report_mismatch($sformatf("rank %0d player got %h want %h",
                                   want.rank, got.entry_player, want.entry_player));
      if (got.entry_score != want.entry_score)
         report_mismatch($sformatf("rank %0d score got %h want %h",
                                   want.rank, got.entry_score, want.entry_score));
      if (got.last != want.last)
         report_mismatch($sformatf("rank %0d last got %b want %b",
                                   want.rank, got.last, want.last));
   endtask

   // The block never takes an insert while it offers a result; should both transfer on
   // the same edge, the result belongs to an earlier insert, so it is checked first.
   always @(posedge clock) begin
      if (reset) begin
         listing_q.delete();
         ranked_count = 0;
      end else begin
         if (rsp_valid && rsp_ready)
            check_result(rsp_payload);
         if (req_valid && req_ready)
            ranked_insert(req_payload);
      end
      pending    <= listing_q.size();
      fail_count <= mismatches;
   end

endmodule

// ===== sim/descending_score_sorted_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Descending score sorted table testbench
// Drives inserts into the sorted table with random gaps and result stalls,
// first a directed set that fills and overflows the table, then random scores
// biased toward ties and the extremes. A checker beside the block predicts
// every listing; this module gives the verdict.
// ----------------------------------------------------------------------------
module descending_score_sorted_table_tb;

   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 2 * dsst_pkg::TABLE_DEPTH + 8;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   dsst_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   dsst_pkg::rsp_type rsp_payload;
   int                fail_count;
   int                pending;
   bit                hold_request = 1'b0;

   wire req_fire = req_valid && req_ready;
   wire rsp_fire = rsp_valid && rsp_ready;

   descending_score_sorted_table i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   dsst_table_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      else if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Ties and the extremes are favored so that equal scores meet in the table.
   function automatic logic [15:0] pick_score();
      case ($urandom_range(0, 9))
         0:       return 16'hFFFF;
         1:       return 16'h0000;
         2:       return 16'($urandom_range(0, 7));
         3:       return 16'hFFF0 + 16'($urandom_range(0, 15));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic dsst_pkg::req_type make_insert(input logic [15:0] player,
                                                     input logic [15:0] score);
      dsst_pkg::req_type item;
      item.player_id = player;
      item.score     = score;
      return item;
   endfunction

   // Valid stays high across back-to-back transfers and drops only for a gap.
   task automatic send_insert(input dsst_pkg::req_type item, input bit gaps_on);
      int unsigned gap;
      req_payload <= item;
      req_valid   <= 1'b1;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      gap = gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
   endtask

   initial begin : receiver
      int unsigned stall_left;
      int unsigned steady_left;
      int unsigned roll;
      bit          hold_done;
      stall_left  = 0;
      steady_left = 0;
      hold_done   = 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         // One long hold-off while the sender keeps offering inserts.
         if (hold_request && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end
         if (steady_left > 0) begin
            rsp_ready <= 1'b1;
            steady_left--;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 5)
               steady_left = $urandom_range(30, 120);
            else if (roll < 35)
               stall_left = pick_gap();
            rsp_ready <= (stall_left == 0);
            if (stall_left > 0)
               stall_left--;
         end
         @(posedge clock);
      end
   end

   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || req_fire || rsp_fire)
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      bit gaps_on;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Empty table, then ties at both ends of the score range.
      send_insert(make_insert(16'hFFFF, 16'h0000), 1'b1);
      send_insert(make_insert(16'h0000, 16'hFFFF), 1'b1);
      send_insert(make_insert(16'hA5A5, 16'hFFFF), 1'b1);
      send_insert(make_insert(16'h5A5A, 16'h0000), 1'b1);
      // Fill the table to its depth with scattered scores.
      for (int i = 1; i <= dsst_pkg::TABLE_DEPTH - 4; i++)
         send_insert(make_insert(16'h0100 + 16'(i), 16'(i * 16'h1001)), 1'b1);
      // Full table: a score tying the lowest is dropped, a higher one evicts it.
      send_insert(make_insert(16'h1111, 16'h0000), 1'b1);
      send_insert(make_insert(16'h2222, 16'h0001), 1'b1);
      send_insert(make_insert(16'h3333, 16'hFFFF), 1'b1);
      send_insert(make_insert(16'h4444, 16'h0000), 1'b1);
      send_insert(make_insert(16'hC3C3, 16'h3003), 1'b1);

      // The sender rests until every listing so far has been read out.
      wait_drained();

      for (int chunk = 0; chunk < 7; chunk++) begin
         if (chunk == 0) begin
            hold_request = 1'b1;
            gaps_on      = 1'b0;
         end else begin
            gaps_on = ($urandom_range(0, 3) != 0);
         end
         for (int k = 0; k < 20; k++)
            send_insert(make_insert(16'($urandom), pick_score()), gaps_on);
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== descending_score_sorted_table.f =====
design/dsst_pkg.sv
design/dsst_cell.sv
design/descending_score_sorted_table.sv
design/dsst_checker.sv
sim/dsst_table_checker.sv
sim/descending_score_sorted_table_tb.sv
